### rtl/q8bd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q8bd_pkg
// Shared types and constants for the Q8 block dequantizer.
// ----------------------------------------------------------------------------
package q8bd_pkg;

  localparam logic [31:0] QNAN_DEFAULT = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS     = 32'h7F80_0000;

  // Front-end decode handed to the multiply/pack stage
  typedef struct packed {
    logic [15:0] scale;
    logic [7:0]  value;
    logic        block_last;
    logic        row_last;
  } q8bd_item_t;

endpackage

### rtl/q8_block_dequantizer.sv
// A value byte's result is registered after acceptance in the input/parse
// register, then in the multiply/pack result register.
// Throughput: one byte per cycle when not stalled; scale bytes produce no result.
// Stall backs up through the two registers combinationally, in the same cycle.
// Reset clears position, scale and valid flags asynchronously.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q8_block_dequantizer
// Streams Q8_0 blocks and emits single-precision weights.
// ----------------------------------------------------------------------------
module q8_block_dequantizer #(
  parameter int BLOCK_VALUES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        row_start_i,
  input  logic        row_end_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] value_bits_o,
  output logic        block_last_o,
  output logic        row_last_o
);
  import q8bd_pkg::*;

  q8bd_item_t item;
  logic       item_valid, item_stall;

  q8bd_parser #(.BLOCK_VALUES(BLOCK_VALUES)) u_parser (
    .clk_i, .rst_ni, .valid_i, .stall_o, .data_byte_i, .row_start_i, .row_end_i,
    .item_valid_o(item_valid), .item_stall_i(item_stall), .item_o(item)
  );

  q8bd_scaler u_scaler (
    .clk_i, .rst_ni, .item_valid_i(item_valid), .item_stall_o(item_stall),
    .item_i(item), .valid_o, .stall_i, .value_bits_o, .block_last_o, .row_last_o
  );
endmodule

### rtl/q8bd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q8bd_parser
// Tracks block position, assembles the scale and registers value items.
// ----------------------------------------------------------------------------
module q8bd_parser #(
  parameter int BLOCK_VALUES = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  row_start_i,
  input  logic                  row_end_i,
  output logic                  item_valid_o,
  input  logic                  item_stall_i,
  output q8bd_pkg::q8bd_item_t  item_o
);
  import q8bd_pkg::*;

  localparam int PW = $clog2(BLOCK_VALUES + 2);
  localparam logic [PW-1:0] LAST_POS = PW'(BLOCK_VALUES + 1);

  logic [PW-1:0] pos_q, pos_d, pos_cur;
  logic [7:0]    low_q;
  logic [15:0]   scale_q;
  logic          vld_q;
  q8bd_item_t    item_q;
  logic          acc, is_val, last;

  assign stall_o = vld_q && item_stall_i;
  assign acc     = valid_i && !stall_o;
  assign pos_cur = row_start_i ? '0 : pos_q;
  assign is_val  = pos_cur > PW'(1);
  assign last    = pos_cur >= LAST_POS;

  always_comb begin
    if (pos_cur == '0) begin
      pos_d = PW'(1);
    end else if (pos_cur == PW'(1)) begin
      pos_d = PW'(2);
    end else begin
      pos_d = last ? '0 : pos_cur + PW'(1);
    end
    if (row_end_i) pos_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      low_q   <= '0;
      scale_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (acc) begin
        pos_q <= pos_d;
        if (pos_cur == '0) low_q <= data_byte_i;
        if (pos_cur == PW'(1)) scale_q <= {data_byte_i, low_q};
      end
      if (!stall_o) vld_q <= acc && is_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && is_val) begin
      item_q.scale      <= scale_q;
      item_q.value      <= data_byte_i;
      item_q.block_last <= last;
      item_q.row_last   <= row_end_i;
    end
  end

  assign item_valid_o = vld_q;
  assign item_o       = item_q;

`ifndef SYNTH
  ap_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LAST_POS) else $error("position out of range");
  ap_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && row_end_i |=> pos_q == '0) else $error("row end did not clear position");
  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && item_stall_i |=> vld_q && $stable(item_q)) else $error("item lost");
`endif
endmodule

### rtl/q8bd_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q8bd_scaler
// Exact half * int8 product packed as single precision, output register.
// ----------------------------------------------------------------------------
module q8bd_scaler (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  output logic                  item_stall_o,
  input  q8bd_pkg::q8bd_item_t  item_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output logic [31:0]           value_bits_o,
  output logic                  block_last_o,
  output logic                  row_last_o
);
  import q8bd_pkg::*;

  logic        hs, qneg;
  logic [4:0]  he;
  logic [9:0]  hm;
  logic [7:0]  mag;
  logic [10:0] sig;
  logic [4:0]  ex;
  logic [17:0] prod;
  logic [4:0]  k;
  logic [31:0] res, bits_q;
  logic [40:0] sh;
  logic [7:0]  fexp;
  logic        vld_q, bl_q, rl_q;

  assign hs   = item_i.scale[15];
  assign he   = item_i.scale[14:10];
  assign hm   = item_i.scale[9:0];
  assign qneg = item_i.value[7];
  assign mag  = qneg ? 8'(-item_i.value) : item_i.value;
  assign sig  = (he != '0) ? {1'b1, hm} : {1'b0, hm};
  assign ex   = (he != '0) ? he : 5'd1;
  assign prod = 18'(sig) * 18'(mag);

  // leading one search over 18 bits (priority encoder)
  always_comb begin
    k = '0;
    for (int i = 0; i < 18; i++) begin
      if (prod[i]) k = 5'(i);
    end
  end

  assign sh   = {23'b0, prod} << (5'd23 - k);
  assign fexp = 8'(k) + 8'(ex) + 8'd102;

  always_comb begin
    if (he == 5'h1F) begin
      if (hm != '0) res = {hs, QNAN_DEFAULT[30:0]} | {9'b0, hm, 13'b0};
      else if (mag == '0) res = QNAN_DEFAULT;
      else res = {hs ^ qneg, INF_BITS[30:0]};
    end else if (prod == '0) begin
      res = {hs ^ qneg, 31'b0};
    end else begin
      res = {hs ^ qneg, fexp, sh[22:0]};
    end
  end

  assign item_stall_o = vld_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (!item_stall_o) vld_q <= item_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (!item_stall_o && item_valid_i) begin
      bits_q <= res;
      bl_q   <= item_i.block_last;
      rl_q   <= item_i.row_last;
    end
  end

  assign valid_o      = vld_q;
  assign value_bits_o = bits_q;
  assign block_last_o = bl_q;
  assign row_last_o   = rl_q;

`ifndef SYNTH
  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && stall_i |=> vld_q && $stable(bits_q)) else $error("result lost");
  ap_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && !item_stall_o |=> vld_q) else $error("item dropped");
  ap_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_stall_o |-> vld_q) else $error("stall without result");
`endif
endmodule
